// File: src/assert_macros.svh
// Assertion macros used by the RTL of the next-digit-permutation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ndp_pkg.sv
// Types and constants of the next-digit-permutation block.
`default_nettype none

package ndp_pkg;

  localparam int unsigned VAL_W     = 31;
  localparam int unsigned ACC_W     = 34;  // holds any ten-digit decimal number
  localparam int unsigned DIG_W     = 4;
  localparam int unsigned DIGITS    = 10;  // decimal digits of a 31-bit value
  localparam int unsigned DIG_IDX_W = $clog2(DIGITS);

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [ACC_W-1:0] VALUE_MAX = ACC_W'(34'd2147483647);

  typedef logic [VAL_W-1:0] value_t;
  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [DIG_W-1:0] digit_t;
  typedef logic [DIG_IDX_W-1:0] dig_cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_ROT,
    S_HORN_S,
    S_HORN,
    S_FIN
  } ndp_state_t;

  typedef struct packed {
    logic take_in;
    logic dig;
    logic rot;
    logic horn_s;
    logic horn;
    logic load_out;
  } ndp_ctrl_t;

endpackage

`default_nettype wire

// File: src/ndp_if.sv
// Valid/ready channel interfaces for the request and result beats.
`default_nettype none

interface ndp_in_if;
  logic               valid;
  logic               ready;
  logic [ndp_pkg::VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ndp_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [ndp_pkg::VAL_W-1:0] next_value;

  modport source (output valid, output found, output next_value, input ready);
  modport sink   (input valid, input found, input next_value, output ready);
endinterface

`default_nettype wire

// File: src/ndp_div10.sv
// Registered divide-by-ten of a 31-bit value by reciprocal multiplication.
`default_nettype none

module ndp_div10 (
  input  wire logic                 clk,
  input  wire logic [ndp_pkg::VAL_W-1:0] v_i,
  output logic      [ndp_pkg::VAL_W-1:0] q_o
);
  import ndp_pkg::*;

  logic [63:0] prod_w;
  logic [VAL_W-1:0] q_r;

  assign prod_w = 64'({1'b0, v_i}) * 64'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= VAL_W'(prod_w >> RECIP_SHIFT);
  end

  assign q_o = q_r;

endmodule

`default_nettype wire

// File: src/next_digit_permutation_unit.sv
// Top level: next larger number with the same decimal digits, one sequencer.
`default_nettype none

`include "assert_macros.svh"

// Each request beat carries a 31-bit value; the block answers with one result
// beat holding the smallest larger number built from the same decimal digits,
// or found = 0 and next_value = 0 when no larger arrangement exists or it does
// not fit in 31 bits. Digits are peeled off least significant first by a
// shared divide-by-ten multiplier (for each digit: multiply, then digit and
// compare) until the pivot digit shows up; the digits passed on the way go
// into a small queue. One rotation pass over the queue swaps in the pivot, and
// a multiply-by-ten accumulator rebuilds the number. The last step waits
// while an earlier beat still holds the output register. The block takes one
// request at a time and is ready only when idle; a finished result sits in
// its own output register, so a new request can be taken while that beat is
// still waiting. No state survives between requests.
module next_digit_permutation_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ndp_in_if.sink    in_bus,
  ndp_out_if.source out_bus
);
  import ndp_pkg::*;

  ndp_state_t state_r, state_nxt;
  ndp_ctrl_t  ctl;

  // working registers
  value_t   v_r;
  value_t   q_w;
  logic     first_r;
  logic     nf_r;       // no pivot: answer is not found
  digit_t   prev_r;
  digit_t   p_r;        // pivot digit
  digit_t   s_r;        // digit swapped into the pivot place
  logic     swapped_r;
  logic [DIG_IDX_W-1:0] cnt_r;  // queued tail digits
  logic [DIG_IDX_W-1:0] rc_r;   // rotate / rebuild countdown
  acc_t     acc_r;
  digit_t   dq_r [DIGITS];

  // result register
  logic     out_valid_r;
  logic     out_found_r;
  value_t   out_next_r;

  logic     in_ready_w;
  digit_t   dig_w;
  logic     q_zero_w;
  logic     piv_w;
  logic     big_w;
  acc_t     q_x10_w;
  acc_t     acc_x10_w;
  logic     found_w;
  logic [DIG_IDX_W-1:0] last_w;

  ndp_div10 u_div10 (
    .clk (clk),
    .v_i (v_r),
    .q_o (q_w)
  );

  // digit = v - 10 * floor(v / 10)
  assign q_x10_w  = (ACC_W'(q_w) << 3) + (ACC_W'(q_w) << 1);
  assign dig_w    = DIG_W'(v_r - VAL_W'(q_x10_w));
  assign q_zero_w = (q_w == '0);
  assign piv_w    = !first_r && (dig_w < prev_r);

  // first tail digit larger than the pivot takes the pivot's place
  assign big_w     = !swapped_r && (dq_r[0] > p_r);
  assign acc_x10_w = (acc_r << 3) + (acc_r << 1);
  assign last_w    = DIG_IDX_W'(cnt_r - 1'b1);
  assign found_w   = !nf_r && (acc_r <= VALUE_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIG;
      end
      S_DIG: begin
        priority if (piv_w) state_nxt = S_ROT;
        else if (q_zero_w)  state_nxt = S_FIN;
        else                state_nxt = S_MUL;
      end
      S_ROT: begin
        if (rc_r == DIG_IDX_W'(1)) state_nxt = S_HORN_S;
      end
      S_HORN_S: begin
        state_nxt = S_HORN;
      end
      S_HORN: begin
        if (rc_r == DIG_IDX_W'(1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_bus.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    ctl        = '0;
    in_ready_w = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready_w  = 1'b1;
        ctl.take_in = in_bus.valid;
      end
      S_MUL:    ;
      S_DIG:    ctl.dig    = 1'b1;
      S_ROT:    ctl.rot    = 1'b1;
      S_HORN_S: ctl.horn_s = 1'b1;
      S_HORN:   ctl.horn   = 1'b1;
      S_FIN:    ctl.load_out = !out_valid_r || out_bus.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      v_r       <= in_bus.value;
      first_r   <= 1'b1;
      nf_r      <= 1'b0;
      swapped_r <= 1'b0;
      cnt_r     <= '0;
    end

    if (ctl.dig) begin
      if (piv_w) begin
        p_r   <= dig_w;
        acc_r <= ACC_W'(q_w);       // untouched upper digits
        rc_r  <= cnt_r;
      end else begin
        dq_r[cnt_r] <= dig_w;
        cnt_r       <= DIG_IDX_W'(cnt_r + 1'b1);
        prev_r      <= dig_w;
        first_r     <= 1'b0;
        v_r         <= q_w;
        if (q_zero_w) nf_r <= 1'b1;
      end
    end

    // rotate the queue once, swapping the pivot digit in on the way
    if (ctl.rot) begin
      for (int k = 0; k < DIGITS - 1; k++) begin
        if (DIG_IDX_W'(k) == last_w) begin
          dq_r[k] <= big_w ? p_r : dq_r[0];
        end else begin
          dq_r[k] <= dq_r[k+1];
        end
      end
      if (big_w) begin
        s_r       <= dq_r[0];
        swapped_r <= 1'b1;
      end
      rc_r <= DIG_IDX_W'(rc_r - 1'b1);
    end

    if (ctl.horn_s) begin
      acc_r <= acc_x10_w + ACC_W'(s_r);
      rc_r  <= cnt_r;
    end

    // tail digits in queue order are the new low digits, most significant first
    if (ctl.horn) begin
      for (int k = 0; k < DIGITS - 1; k++) begin
        dq_r[k] <= dq_r[k+1];
      end
      acc_r <= acc_x10_w + ACC_W'(dq_r[0]);
      rc_r  <= DIG_IDX_W'(rc_r - 1'b1);
    end

    if (ctl.load_out) begin
      out_found_r <= found_w;
      out_next_r  <= found_w ? acc_r[VAL_W-1:0] : '0;
    end
  end

  assign in_bus.ready       = in_ready_w;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.found      = out_found_r;
  assign out_bus.next_value = out_next_r;

  `NDP_ASSERT_NOW(a_nf_zero, out_valid_r && !out_found_r, out_next_r == '0, "nf value not zero")
  `NDP_ASSERT_NOW(a_rot_tail, state_r == S_ROT, rc_r != '0 && cnt_r != '0, "empty rotation tail")
  `NDP_ASSERT_NOW(a_swap_done, state_r == S_HORN_S, swapped_r, "rebuild started without a swap")
  `NDP_ASSERT_NEXT(a_busy, in_bus.valid && in_bus.ready, state_r == S_MUL, "no step after accept")

endmodule

`default_nettype wire

// File: tb/sv/next_perm_checker.sv
// Checker for the next-digit-permutation block: predicts each result and compares it.
module next_perm_checker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire ndp_pkg::value_t in_value,
  input  wire logic            out_valid,
  input  wire logic            out_ready,
  input  wire logic            out_found,
  input  wire ndp_pkg::value_t out_next_value,
  output int unsigned          pending_results,
  output int unsigned          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ndp_pkg::*;

  typedef struct packed {
    value_t request;
    logic   found;
    value_t next_value;
  } perm_result_t;

  perm_result_t expected_results [$];
  int unsigned  mismatch_count = 0;

  initial begin
    pending_results = 0;
    fail_count      = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %0s", $realtime, what);
    mismatch_count++;
  endtask

  // Smallest larger number with the same decimal digits, if it fits in 31 bits.
  function automatic perm_result_t predict_next_perm(input value_t v);
    digit_t       msd [DIGITS];
    digit_t       lsd [DIGITS];
    value_t       rem;
    acc_t         acc;
    digit_t       t;
    int           n;
    int           piv;
    int           hi;
    int           lo;
    perm_result_t r;
    r.request    = v;
    r.found      = 1'b0;
    r.next_value = '0;
    rem = v;
    n   = 0;
    acc = '0;
    do begin
      lsd[n] = digit_t'(rem % 10);
      rem    = rem / 10;
      n++;
    end while (rem != 0 && n < DIGITS);
    for (lo = 0; lo < n; lo++) msd[lo] = lsd[n - 1 - lo];
    piv = n - 2;
    while (piv >= 0 && msd[piv] >= msd[piv + 1]) piv--;
    if (piv < 0) return r;
    hi = n - 1;
    while (hi > piv && msd[hi] <= msd[piv]) hi--;
    t        = msd[piv];
    msd[piv] = msd[hi];
    msd[hi]  = t;
    lo = piv + 1;
    hi = n - 1;
    while (lo < hi) begin
      t       = msd[lo];
      msd[lo] = msd[hi];
      msd[hi] = t;
      lo++;
      hi--;
    end
    for (lo = 0; lo < n; lo++) acc = acc * 10 + acc_t'(msd[lo]);
    if (acc <= VALUE_MAX) begin
      r.found      = 1'b1;
      r.next_value = acc[VAL_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    perm_result_t want;
    if (rst_n) begin
      // retire first, so a stray result never matches a same-cycle request
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: found=%0b next=%0d",
                                    out_found, out_next_value));
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("value %0d: found %0b, want %0b",
                                      want.request, out_found, want.found));
          if (out_next_value !== want.next_value)
            report_mismatch($sformatf("value %0d: next_value %0d, want %0d",
                                      want.request, out_next_value, want.next_value));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_next_perm(in_value));
    end
    pending_results <= expected_results.size();
    fail_count      <= mismatch_count;
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, request and result traffic, and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ndp_pkg::*;

  // Run length and traffic shaping
  localparam int unsigned RANDOM_BEATS = 1530;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned IDLE_PCT     = 7;
  // sender keeps valid up with no gaps over this range of beats
  localparam int unsigned TX_QUIET_LO  = 500;
  localparam int unsigned TX_QUIET_HI  = 800;
  // receiver: one long hold-off, and a window with ready stuck high
  localparam int unsigned HOLD_START   = 3000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RX_QUIET_LO  = 20000;
  localparam int unsigned RX_QUIET_HI  = 30000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned pending_results;
  int unsigned fail_count;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;

  ndp_in_if  req_bus ();
  ndp_out_if res_bus ();

  always #2 clk = ~clk;

  next_digit_permutation_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (req_bus),
    .out_bus (res_bus)
  );

  next_perm_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (req_bus.valid),
    .in_ready        (req_bus.ready),
    .in_value        (req_bus.value),
    .out_valid       (res_bus.valid),
    .out_ready       (res_bus.ready),
    .out_found       (res_bus.found),
    .out_next_value  (res_bus.next_value),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  // Request values: a mix that hits full bit patterns, repeated digits,
  // non-increasing digit runs (no larger permutation) and the overflow zone
  // just under the 31-bit maximum.
  function automatic value_t random_request();
    acc_t        acc;
    int          n;
    int          kind;
    int          lo;
    int unsigned counts [10];
    acc  = '0;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      return value_t'($urandom);
    end else if (kind < 55) begin
      // random digit string, narrow digit alphabet half the time for repeats
      n  = $urandom_range(1, DIGITS);
      lo = $urandom_range(0, 7);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) acc = acc * 10 + acc_t'($urandom_range(lo, lo + 2));
        else acc = acc * 10 + acc_t'($urandom_range(0, 9));
      end
      if (acc > VALUE_MAX) acc = acc_t'(acc[VAL_W-1:0]);
      return acc[VAL_W-1:0];
    end else if (kind < 70) begin
      // digits in non-increasing order
      n = $urandom_range(1, DIGITS - 1);
      for (int d = 0; d < 10; d++) counts[d] = 0;
      for (int i = 0; i < n; i++) counts[$urandom_range(0, 9)]++;
      for (int d = 9; d >= 0; d--)
        for (int k = 0; k < counts[d]; k++) acc = acc * 10 + acc_t'(d);
      return acc[VAL_W-1:0];
    end else if (kind < 85) begin
      // near the top: next permutation often overflows
      acc = VALUE_MAX - acc_t'($urandom_range(0, 50000000));
      return acc[VAL_W-1:0];
    end else begin
      return value_t'($urandom_range(0, 999));
    end
  endfunction

  // Offer one request beat and hold it until the block takes it; then maybe
  // drop valid for a short random gap. Valid is only lowered on a gap, never
  // toggled within one step.
  task automatic send_request(input value_t v);
    req_bus.valid <= 1'b1;
    req_bus.value <= v;
    do @(posedge clk); while (!req_bus.ready);
    beats_sent++;
    if (!(beats_sent >= TX_QUIET_LO && beats_sent < TX_QUIET_HI) &&
        $urandom_range(0, 99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      req_bus.value <= value_t'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Sender and verdict
  initial begin
    value_t directed_values [$];
    rst_n         <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.value <= '0;
    // zero, single digits, two-digit swaps, repeats, sorted runs, the
    // 31-bit maximum, a result landing exactly on it, overflow cases, bit patterns
    directed_values = '{31'd0, 31'd1, 31'd9, 31'd10, 31'd12, 31'd21, 31'd115, 31'd1221,
                        31'd534976, 31'd1111111111, 31'd999999999, 31'd1000000000,
                        31'd1234567890, 31'd1987654321, 31'd1999999999, 31'd2147483476,
                        31'd2147483646, 31'd2147483647, 31'd1073741824, 31'd1431655765,
                        31'd715827882, 31'd987654321, 31'd1463847412};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) send_request(directed_values[i]);
    for (int i = 0; i < RANDOM_BEATS; i++) send_request(random_request());
    req_bus.valid <= 1'b0;

    // drain: let the count take in the last request, wait for every expected
    // result, then a few more cycles for strays
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random ready with ~7% idle, one long hold-off to back the block
  // up into its input, and a long window with no idling.
  initial begin
    int unsigned rx_cycles;
    rx_cycles = 0;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) begin
        res_bus.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          @(posedge clk);
          rx_cycles++;
        end
      end else if (rx_cycles >= RX_QUIET_LO && rx_cycles < RX_QUIET_HI) begin
        res_bus.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/ndp_pkg.sv
src/ndp_if.sv
src/ndp_div10.sv
src/next_digit_permutation_unit.sv
tb/sv/next_perm_checker.sv
tb/sv/testbench.sv
